// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared definitions for the serial frame receiver
// Start and end byte codes, result kinds and the result record passed
// from the frame tracker to the output register.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int unsigned BYTES_PER_WORD_DEF = 4;
	localparam int unsigned MAX_WORD_COUNT     = 255;

	localparam logic [7:0] START_BYTE = 8'h01;
	localparam logic [7:0] END_BYTE   = 8'h04;

	typedef enum logic [1:0] {
		KIND_WORD = 2'd0,
		KIND_GOOD = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	typedef struct packed {
		logic        vld;
		kind_t       kind;
		logic [31:0] word;
		logic [7:0]  hdr;
		logic [7:0]  cnt;
	} result_t;

endpackage

// File: rtl/serial_frame_receiver.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver: byte stream deframer
// Finds frames opened by a start byte, captures header and word count,
// packs the payload into little-endian words and reports each frame end.
//
//   channel  signals                                   direction
//   -------  ----------------------------------------  ---------
//   in       in_valid, in_stall, rx_byte               into block
//   out      out_valid, out_stall, kind, data_word,    out of block
//            frame_header, word_count
//
// One byte is taken per cycle while in_stall is low. A byte waits in the
// input register and its result, if any, is loaded into the output register
// when the byte is processed.
// Reset clears the frame state and both valid flags; the block comes out of
// reset idle, waiting for a start byte.
// While a result waits in the output register the input register still
// drains bytes that give no result; in_stall rises only when a byte that
// gives a result finds the output register full and stalled.
// ----------------------------------------------------------------------------
module serial_frame_receiver #(
	parameter int unsigned BYTES_PER_WORD = sfr_pkg::BYTES_PER_WORD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [31:0] data_word,
	output logic [7:0]  frame_header,
	output logic [7:0]  word_count
);
	import sfr_pkg::*;

	logic       s1_vld_q;
	logic [7:0] byte_s1;
	logic       in_take;
	logic       fire;
	result_t    core_res;
	result_t    res_q;

	// A transfer on the input side happens when valid is high and we are not
	// stalling. The input register frees up whenever its byte is processed.
	assign in_take  = in_valid && !in_stall;
	assign in_stall = s1_vld_q && !fire;

	// The byte in the input register is processed unless it would produce a
	// result while the output register holds one that is not being taken.
	assign fire = s1_vld_q && (!core_res.vld || !res_q.vld || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (in_take) begin
			s1_vld_q <= 1'b1;
		end else if (fire) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= rx_byte;
		end
	end

	sfr_core #(
		.BYTES_PER_WORD(BYTES_PER_WORD)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.rx_byte(byte_s1),
		.res    (core_res)
	);

	// Output register: loaded by a processed byte that yields a result,
	// emptied when the downstream side takes the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (fire && core_res.vld) begin
			res_q <= core_res;
		end else if (!out_stall) begin
			res_q.vld <= 1'b0;
		end
	end

	assign out_valid    = res_q.vld;
	assign kind         = res_q.kind;
	assign data_word    = res_q.word;
	assign frame_header = res_q.hdr;
	assign word_count   = res_q.cnt;

`ifndef SYNTHESIS
	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_vld_q)
		else $error("input stalled with an empty input register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fire && core_res.vld |-> !res_q.vld || !out_stall)
		else $error("result overwrote a waiting transfer");

	a_end_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_WORD |-> data_word == 32'd0)
		else $error("frame end carries a non-zero word");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> core_res.vld && res_q.vld && out_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule

// File: rtl/sfr_core.sv
// ----------------------------------------------------------------------------
// sfr_core: frame tracker
// Holds the deframing state and works out the result of one byte in a
// single pass; the state advances when fire is high.
// ----------------------------------------------------------------------------
module sfr_core #(
	parameter int unsigned BYTES_PER_WORD = sfr_pkg::BYTES_PER_WORD_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [7:0]       rx_byte,
	output sfr_pkg::result_t res
);
	import sfr_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_WORD_COUNT * BYTES_PER_WORD + 3);
	localparam int unsigned IDX_W = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;
	localparam int unsigned LANES = (BYTES_PER_WORD < 4) ? BYTES_PER_WORD : 4;

	logic             in_frame_q, in_frame_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic [CNT_W-1:0] end_q, end_n;
	logic [IDX_W-1:0] idx_q, idx_n;
	logic [31:0]      asm_q, asm_n;
	logic [7:0]       hdr_q, hdr_n;
	logic [7:0]       wcnt_q, wcnt_n;
	logic [31:0]      word_new;

	// Only the low four bytes of a word reach the output, so wider words
	// drop their upper bytes on the way in.
	always_comb begin
		word_new = asm_q;
		for (int i = 0; i < LANES; i++) begin
			if (4'(idx_q) == 4'(i)) begin
				word_new[i*8 +: 8] = rx_byte;
			end
		end
	end

	always_comb begin
		in_frame_n = in_frame_q;
		cnt_n      = cnt_q;
		end_n      = end_q;
		idx_n      = idx_q;
		asm_n      = asm_q;
		hdr_n      = hdr_q;
		wcnt_n     = wcnt_q;
		res        = '0;
		res.hdr    = hdr_q;
		res.cnt    = wcnt_q;
		if (!in_frame_q) begin
			if (rx_byte == START_BYTE) begin
				in_frame_n = 1'b1;
				cnt_n      = '0;
				idx_n      = '0;
				asm_n      = '0;
			end
		end else if (cnt_q == CNT_W'(0)) begin
			hdr_n = rx_byte;
			cnt_n = cnt_q + CNT_W'(1);
		end else if (cnt_q == CNT_W'(1)) begin
			wcnt_n = rx_byte;
			end_n  = CNT_W'(CNT_W'(rx_byte) * CNT_W'(BYTES_PER_WORD) + CNT_W'(2));
			cnt_n  = cnt_q + CNT_W'(1);
		end else if (cnt_q == end_q) begin
			res.vld    = 1'b1;
			res.kind   = (rx_byte == END_BYTE) ? KIND_GOOD : KIND_BAD;
			in_frame_n = 1'b0;
			cnt_n      = '0;
			idx_n      = '0;
			asm_n      = '0;
		end else begin
			cnt_n = cnt_q + CNT_W'(1);
			if (idx_q == IDX_W'(BYTES_PER_WORD - 1)) begin
				res.vld  = 1'b1;
				res.kind = KIND_WORD;
				res.word = word_new;
				idx_n    = '0;
				asm_n    = '0;
			end else begin
				idx_n = idx_q + IDX_W'(1);
				asm_n = word_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
			idx_q      <= '0;
			asm_q      <= '0;
			hdr_q      <= '0;
			wcnt_q     <= '0;
		end else if (fire) begin
			in_frame_q <= in_frame_n;
			cnt_q      <= cnt_n;
			idx_q      <= idx_n;
			asm_q      <= asm_n;
			hdr_q      <= hdr_n;
			wcnt_q     <= wcnt_n;
		end
	end

	// End position is always written by the count byte before it is compared.
	always_ff @(posedge clk) begin
		if (fire) begin
			end_q <= end_n;
		end
	end

endmodule
